// ----- design/mlpbp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpbp_pkg
// Shared constants, request codes and fixed-point helpers for the two-layer
// perceptron training engine.
// ----------------------------------------------------------------------------
package mlpbp_pkg;

    localparam int FRAC        = 16;
    localparam int VAL_W       = 24;
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    localparam int SIG_SHIFT   = FRAC + 4 - SIG_IDX_W;
    localparam int SIG_W       = FRAC + 1;
    localparam int EXP_FRAC    = 28;
    localparam int LR_W        = 23;

    localparam longint ONE_L    = longint'(1) << FRAC;
    localparam longint LR_RAW   = (152 * ONE_L + 5) / 10;
    localparam longint LR_CAP   = (LR_RAW > 64'sd8388607) ? 64'sd8388607 : LR_RAW;
    localparam logic [LR_W-1:0] LR_RESET = LR_W'(LR_CAP);
    localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(ONE_L);

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_TRAIN   = 2'd1,
        REQ_PREDICT = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    function automatic logic signed [VAL_W-1:0] qsat(input logic signed [47:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 48'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -48'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = VAL_W'(v);
        end
        return r;
    endfunction

    // Restoring division of non-negative operands, used only while the
    // sigmoid table is built at elaboration.
    function automatic longint udiv(input longint a, input longint b);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b_i = 62; b_i >= 0; b_i--) begin
            r = (r <<< 1) | ((a >>> b_i) & longint'(1));
            q = q <<< 1;
            if (r >= b) begin
                r = r - b;
                q = q | longint'(1);
            end
        end
        return q;
    endfunction

    function automatic logic [SIG_W-1:0] sig_entry(input int i);
        longint d;
        longint p;
        longint term;
        longint e;
        longint num;
        longint den;
        logic   done;
        d    = 16 * longint'(i) - 8 * longint'(SIG_ENTRIES);
        p    = (d < 0) ? -d : d;
        term = longint'(1) << EXP_FRAC;
        e    = term;
        done = 1'b0;
        for (int n = 1; n < 400; n++) begin
            if (!done) begin
                term = udiv(term * p, longint'(n) * SIG_ENTRIES);
                if (term == 0) begin
                    done = 1'b1;
                end else begin
                    e = e + term;
                end
            end
        end
        num = (d >= 0) ? e : (longint'(1) << EXP_FRAC);
        den = e + (longint'(1) << EXP_FRAC);
        return SIG_W'(udiv(num * ONE_L + (den >>> 1), den));
    endfunction

endpackage

// ----- design/mlpbp_req_if.sv -----
// ----------------------------------------------------------------------------
// mlpbp_req_if
// Request channel: one transaction carries one write, train, predict or unused-code request.
// ----------------------------------------------------------------------------
interface mlpbp_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic signed [23:0] feature_a;
    logic signed [23:0] feature_b;
    logic signed [23:0] target;
    logic [4:0]        weight_index;
    logic signed [23:0] weight_value;

    modport source (output valid, req_type, feature_a, feature_b, target,
                    weight_index, weight_value, input ready);
    modport sink   (input valid, req_type, feature_a, feature_b, target,
                    weight_index, weight_value, output ready);
endinterface

// ----- design/mlpbp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mlpbp_rsp_if
// Response channel: one transaction carries the network output.
// ----------------------------------------------------------------------------
interface mlpbp_rsp_if;
    logic        valid;
    logic        ready;
    logic [16:0] prediction;

    modport source (output valid, prediction, input ready);
    modport sink   (input valid, prediction, output ready);
endinterface

// ----- design/mlpbp_sigmoid.sv -----
// ----------------------------------------------------------------------------
// mlpbp_sigmoid
// Sigmoid by nearest-entry table lookup over [-8,8), saturating outside.
// ----------------------------------------------------------------------------
module mlpbp_sigmoid (
    input  logic signed [mlpbp_pkg::VAL_W-1:0] i_x,
    output logic [mlpbp_pkg::SIG_W-1:0]        o_y
);

    localparam logic signed [25:0] OFFSET = 26'sd8 <<< mlpbp_pkg::FRAC;
    localparam logic signed [25:0] HALF   = 26'sd1 <<< (mlpbp_pkg::SIG_SHIFT - 1);
    localparam logic signed [25:0] TOP    = 26'(mlpbp_pkg::SIG_ENTRIES - 1);

    logic [mlpbp_pkg::SIG_W-1:0]     w_rom [mlpbp_pkg::SIG_ENTRIES];
    logic signed [25:0]              w_off;
    logic signed [25:0]              w_sh;
    logic [mlpbp_pkg::SIG_IDX_W-1:0] w_idx;

    for (genvar g = 0; g < mlpbp_pkg::SIG_ENTRIES; g++) begin : g_rom
        localparam logic [mlpbp_pkg::SIG_W-1:0] ENTRY = mlpbp_pkg::sig_entry(g);
        assign w_rom[g] = ENTRY;
    end

    always_comb begin
        w_off = 26'(i_x) + OFFSET;
        w_sh  = (w_off + HALF) >>> mlpbp_pkg::SIG_SHIFT;
        if (w_off < 0) begin
            w_idx = '0;
        end else if (w_sh > TOP) begin
            w_idx = '1;
        end else begin
            w_idx = w_sh[mlpbp_pkg::SIG_IDX_W-1:0];
        end
    end

    assign o_y = w_rom[w_idx];

endmodule

// ----- design/mlp_backprop_train_step.sv -----
// ----------------------------------------------------------------------------
// mlp_backprop_train_step
// Two-input, sigmoid-hidden, one-output perceptron with SGD backpropagation.
// ----------------------------------------------------------------------------
// The request channel takes one transaction at a time: a weight write, a
// predict or a train step. Every request gives exactly one response
// transaction with the network output (zero for writes and unused codes).
// The learning rate register is loaded through i_cfg_we and i_cfg_data.
// All arithmetic runs through one shared multiplier and one saturating
// adder under a sequencer, so the request channel is not ready while a
// request is in progress. A write goes straight to the response; a
// predict runs the hidden and output layers, and a train step then also
// computes the deltas and updates every weight and bias, all through
// serial use of the multiplier and adder.
// The response is held in an output register until the receiver takes it;
// a new request is accepted in the cycle after that.
// Reset clears all weights and biases to zero and loads the default
// learning rate.
// ----------------------------------------------------------------------------
module mlp_backprop_train_step #(
    parameter int HIDDEN_NODES = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mlpbp_req_if.sink                     i_req,
    mlpbp_rsp_if.source                   o_rsp,
    input  logic                          i_cfg_we,
    input  logic [mlpbp_pkg::LR_W-1:0]    i_cfg_data
);

    localparam int H   = HIDDEN_NODES;
    localparam int JW  = (H > 1) ? $clog2(H) : 1;
    localparam int HWW = $clog2(2 * H);
    localparam int VW  = mlpbp_pkg::VAL_W;
    localparam int SW  = mlpbp_pkg::SIG_W;

    typedef enum logic [4:0] {
        S_IDLE, S_H_MUL, S_H_ADD, S_H_SIG, S_O_MUL, S_O_ADD, S_O_SIG,
        S_T_E, S_T_D1, S_T_DOUT, S_T_DH1, S_T_DH2, S_T_DH3, S_T_OB, S_T_OBA,
        S_T_OW1, S_T_OW2, S_T_OW3, S_T_HB1, S_T_HB2, S_T_HW1, S_T_HW2,
        S_T_HW3, S_OUT
    } t_state;

    t_state                r_state;
    logic [JW-1:0]         r_j;
    logic                  r_k;
    mlpbp_pkg::t_req       r_req;
    logic signed [VW-1:0]  r_x0, r_x1, r_tgt;
    logic signed [VW-1:0]  r_acc, r_t, r_t2, r_e, r_dout;
    logic [SW-1:0]         r_out;
    logic [SW-1:0]         r_pred;
    logic [SW-1:0]         r_h  [H];
    logic signed [VW-1:0]  r_dh [H];
    logic signed [VW-1:0]  r_hw [2*H];
    logic signed [VW-1:0]  r_hb [H];
    logic signed [VW-1:0]  r_ow [H];
    logic signed [VW-1:0]  r_ob;
    logic [mlpbp_pkg::LR_W-1:0] r_lr;

    logic signed [VW-1:0]  w_ma, w_mb, w_aa, w_ab, w_mq, w_as;
    logic signed [47:0]    w_prod;
    logic signed [VW-1:0]  w_hx, w_ox, w_lrx, w_xk;
    logic [HWW-1:0]        w_hidx;
    logic [SW-1:0]         w_sig;
    logic                  w_last;
    logic [6:0]            w_widx;

    mlpbp_sigmoid u_sigmoid (
        .i_x (r_acc),
        .o_y (w_sig)
    );

    assign w_hx   = VW'(r_h[r_j]);
    assign w_ox   = VW'(r_out);
    assign w_lrx  = VW'(r_lr);
    assign w_xk   = r_k ? r_x1 : r_x0;
    assign w_hidx = r_k ? (HWW'(H) + HWW'(r_j)) : HWW'(r_j);
    assign w_last = (r_j == JW'(H - 1));
    assign w_widx = 7'(i_req.weight_index);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_aa = '0;
        w_ab = '0;
        case (r_state)
            S_H_MUL:  begin w_ma = w_xk;   w_mb = r_hw[w_hidx];       end
            S_H_ADD:  begin w_aa = r_acc;  w_ab = r_t;                end
            S_O_MUL:  begin w_ma = w_hx;   w_mb = r_ow[r_j];          end
            S_O_ADD:  begin w_aa = r_acc;  w_ab = r_t;                end
            S_T_E:    begin w_aa = r_tgt;  w_ab = -w_ox;              end
            S_T_D1:   begin w_ma = w_ox;   w_mb = mlpbp_pkg::ONE_Q - w_ox; end
            S_T_DOUT: begin w_ma = r_e;    w_mb = r_t;                end
            S_T_DH1:  begin w_ma = r_dout; w_mb = r_ow[r_j];          end
            S_T_DH2:  begin w_ma = w_hx;   w_mb = mlpbp_pkg::ONE_Q - w_hx; end
            S_T_DH3:  begin w_ma = r_t;    w_mb = r_t2;               end
            S_T_OB:   begin w_ma = r_dout; w_mb = w_lrx;              end
            S_T_OBA:  begin w_aa = r_ob;   w_ab = r_t;                end
            S_T_OW1:  begin w_ma = w_hx;   w_mb = r_dout;             end
            S_T_OW2:  begin w_ma = r_t;    w_mb = w_lrx;              end
            S_T_OW3:  begin w_aa = r_ow[r_j]; w_ab = r_t;             end
            S_T_HB1:  begin w_ma = r_dh[r_j]; w_mb = w_lrx;           end
            S_T_HB2:  begin w_aa = r_hb[r_j]; w_ab = r_t;             end
            S_T_HW1:  begin w_ma = w_xk;   w_mb = r_dh[r_j];          end
            S_T_HW2:  begin w_ma = r_t;    w_mb = w_lrx;              end
            S_T_HW3:  begin w_aa = r_hw[w_hidx]; w_ab = r_t;          end
            default:  begin w_ma = '0;     w_mb = '0;                 end
        endcase
        w_prod = w_ma * w_mb;
        w_mq   = mlpbp_pkg::qsat(w_prod >>> mlpbp_pkg::FRAC);
        w_as   = mlpbp_pkg::qsat(48'(w_aa) + 48'(w_ab));
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = (r_state == S_OUT);
    assign o_rsp.prediction = r_pred;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
            r_k     <= 1'b0;
            r_lr    <= mlpbp_pkg::LR_RESET;
            r_ob    <= '0;
            for (int i = 0; i < 2 * H; i++) begin
                r_hw[i] <= '0;
            end
            for (int i = 0; i < H; i++) begin
                r_hb[i] <= '0;
                r_ow[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_lr <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req  <= mlpbp_pkg::t_req'(i_req.req_type);
                        r_x0   <= i_req.feature_a;
                        r_x1   <= i_req.feature_b;
                        r_tgt  <= i_req.target;
                        r_pred <= '0;
                        r_j    <= '0;
                        r_k    <= 1'b0;
                        case (mlpbp_pkg::t_req'(i_req.req_type))
                            mlpbp_pkg::REQ_WRITE: begin
                                if (w_widx < 7'(2 * H)) begin
                                    r_hw[HWW'(w_widx)] <= i_req.weight_value;
                                end else if (w_widx < 7'(3 * H)) begin
                                    r_hb[JW'(w_widx - 7'(2 * H))] <= i_req.weight_value;
                                end else if (w_widx < 7'(4 * H)) begin
                                    r_ow[JW'(w_widx - 7'(3 * H))] <= i_req.weight_value;
                                end else if (w_widx == 7'(4 * H)) begin
                                    r_ob <= i_req.weight_value;
                                end
                                r_state <= S_OUT;
                            end
                            mlpbp_pkg::REQ_TRAIN, mlpbp_pkg::REQ_PREDICT: begin
                                r_acc   <= r_hb[0];
                                r_state <= S_H_MUL;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_H_MUL: begin
                    r_t     <= w_mq;
                    r_state <= S_H_ADD;
                end
                S_H_ADD: begin
                    r_acc <= w_as;
                    if (r_k) begin
                        r_k     <= 1'b0;
                        r_state <= S_H_SIG;
                    end else begin
                        r_k     <= 1'b1;
                        r_state <= S_H_MUL;
                    end
                end
                S_H_SIG: begin
                    r_h[r_j] <= w_sig;
                    if (w_last) begin
                        r_j     <= '0;
                        r_acc   <= r_ob;
                        r_state <= S_O_MUL;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_acc   <= r_hb[JW'(r_j + 1'b1)];
                        r_state <= S_H_MUL;
                    end
                end
                S_O_MUL: begin
                    r_t     <= w_mq;
                    r_state <= S_O_ADD;
                end
                S_O_ADD: begin
                    r_acc <= w_as;
                    if (w_last) begin
                        r_state <= S_O_SIG;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_O_MUL;
                    end
                end
                S_O_SIG: begin
                    r_out  <= w_sig;
                    r_pred <= w_sig;
                    r_state <= (r_req == mlpbp_pkg::REQ_TRAIN) ? S_T_E : S_OUT;
                end
                S_T_E: begin
                    r_e     <= w_as;
                    r_state <= S_T_D1;
                end
                S_T_D1: begin
                    r_t     <= w_mq;
                    r_state <= S_T_DOUT;
                end
                S_T_DOUT: begin
                    r_dout  <= w_mq;
                    r_j     <= '0;
                    r_state <= S_T_DH1;
                end
                S_T_DH1: begin
                    r_t     <= w_mq;
                    r_state <= S_T_DH2;
                end
                S_T_DH2: begin
                    r_t2    <= w_mq;
                    r_state <= S_T_DH3;
                end
                S_T_DH3: begin
                    r_dh[r_j] <= w_mq;
                    if (w_last) begin
                        r_j     <= '0;
                        r_state <= S_T_OB;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_T_DH1;
                    end
                end
                S_T_OB: begin
                    r_t     <= w_mq;
                    r_state <= S_T_OBA;
                end
                S_T_OBA: begin
                    r_ob    <= w_as;
                    r_j     <= '0;
                    r_state <= S_T_OW1;
                end
                S_T_OW1: begin
                    r_t     <= w_mq;
                    r_state <= S_T_OW2;
                end
                S_T_OW2: begin
                    r_t     <= w_mq;
                    r_state <= S_T_OW3;
                end
                S_T_OW3: begin
                    r_ow[r_j] <= w_as;
                    if (w_last) begin
                        r_j     <= '0;
                        r_state <= S_T_HB1;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_T_OW1;
                    end
                end
                S_T_HB1: begin
                    r_t     <= w_mq;
                    r_state <= S_T_HB2;
                end
                S_T_HB2: begin
                    r_hb[r_j] <= w_as;
                    r_k       <= 1'b0;
                    r_state   <= S_T_HW1;
                end
                S_T_HW1: begin
                    r_t     <= w_mq;
                    r_state <= S_T_HW2;
                end
                S_T_HW2: begin
                    r_t     <= w_mq;
                    r_state <= S_T_HW3;
                end
                S_T_HW3: begin
                    r_hw[w_hidx] <= w_as;
                    if (r_k) begin
                        r_k <= 1'b0;
                        if (w_last) begin
                            r_state <= S_OUT;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_T_HB1;
                        end
                    end else begin
                        r_k     <= 1'b1;
                        r_state <= S_T_HW1;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the perceptron training engine. Every request is
// run through a local fixed-point model of the network. Each response is
// compared with the oldest prediction. The learning rate is swept between
// phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    NODES     = 4;
    localparam int    RAND_REQS = 1270;
    localparam int    QUIET_TAIL = 150;
    localparam longint Q_MAX    = 64'sd8388607;
    localparam longint Q_MIN    = -64'sd8388608;

    typedef struct {
        mlpbp_pkg::t_req kind;
        logic [23:0] feat_a;
        logic [23:0] feat_b;
        logic [23:0] goal;
        logic [4:0]  widx;
        logic [23:0] wval;
        bit          known;
        logic [16:0] known_out;
    } t_req_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [mlpbp_pkg::LR_W-1:0] cfg_data = '0;

    mlpbp_req_if req_ch();
    mlpbp_rsp_if rsp_ch();

    mlp_backprop_train_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    longint sig_tab [mlpbp_pkg::SIG_ENTRIES];
    longint hw [2*NODES];
    longint hb [NODES];
    longint ow [NODES];
    longint ob;
    longint rate;

    logic [16:0] pending_out [$];
    int  errors = 0;
    int  n_train = 0, n_pred = 0, n_write = 0, n_other = 0, n_rsp = 0;
    bit  quiet = 1'b0;
    int  rsp_stall = 0;

    function automatic longint clip(longint v);
        return (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
    endfunction

    function automatic longint fmul(longint a, longint b);
        return clip((a * b) >>> mlpbp_pkg::FRAC);
    endfunction

    function automatic longint sig_of(longint x);
        longint off;
        longint idx;
        off = x + (longint'(8) << mlpbp_pkg::FRAC);
        if (off < 0) begin
            idx = 0;
        end else begin
            idx = (off * mlpbp_pkg::SIG_ENTRIES + (longint'(8) << mlpbp_pkg::FRAC))
                  / (longint'(16) << mlpbp_pkg::FRAC);
        end
        if (idx > mlpbp_pkg::SIG_ENTRIES - 1) begin
            idx = mlpbp_pkg::SIG_ENTRIES - 1;
        end
        return sig_tab[idx];
    endfunction

    function automatic longint slope(longint y);
        return fmul(y, clip(mlpbp_pkg::ONE_L - y));
    endfunction

    task automatic fill_sigmoid();
        longint d, p, term, e, num, den;
        for (int i = 0; i < mlpbp_pkg::SIG_ENTRIES; i++) begin
            d = 16 * longint'(i) - 8 * longint'(mlpbp_pkg::SIG_ENTRIES);
            p = (d < 0) ? -d : d;
            term = longint'(1) << mlpbp_pkg::EXP_FRAC;
            e = term;
            for (int n = 1; n < 400; n++) begin
                term = term * p / (longint'(n) * mlpbp_pkg::SIG_ENTRIES);
                if (term == 0) break;
                e += term;
            end
            num = (d >= 0) ? e : (longint'(1) << mlpbp_pkg::EXP_FRAC);
            den = e + (longint'(1) << mlpbp_pkg::EXP_FRAC);
            sig_tab[i] = (num * mlpbp_pkg::ONE_L + den / 2) / den;
        end
    endtask

    task automatic clear_network();
        foreach (hw[i]) hw[i] = 0;
        foreach (hb[i]) hb[i] = 0;
        foreach (ow[i]) ow[i] = 0;
        ob = 0;
        rate = mlpbp_pkg::LR_RESET;
    endtask

    function automatic logic [16:0] network_step(t_req_item r);
        longint x [2];
        longint hid [NODES];
        longint dh [NODES];
        longint acc, o, err, dout;
        if (r.kind == mlpbp_pkg::REQ_WRITE) begin
            if (r.widx < 2*NODES) hw[r.widx] = longint'(signed'(r.wval));
            else if (r.widx < 3*NODES) hb[r.widx - 2*NODES] = longint'(signed'(r.wval));
            else if (r.widx < 4*NODES) ow[r.widx - 3*NODES] = longint'(signed'(r.wval));
            else if (r.widx == 4*NODES) ob = longint'(signed'(r.wval));
            return '0;
        end
        if (r.kind == mlpbp_pkg::REQ_NONE) return '0;
        x[0] = longint'(signed'(r.feat_a));
        x[1] = longint'(signed'(r.feat_b));
        for (int j = 0; j < NODES; j++) begin
            acc = hb[j];
            for (int k = 0; k < 2; k++) acc = clip(acc + fmul(x[k], hw[k*NODES + j]));
            hid[j] = sig_of(acc);
        end
        acc = ob;
        for (int k = 0; k < NODES; k++) acc = clip(acc + fmul(hid[k], ow[k]));
        o = sig_of(acc);
        if (r.kind == mlpbp_pkg::REQ_TRAIN) begin
            err = clip(longint'(signed'(r.goal)) - o);
            dout = fmul(err, slope(o));
            for (int j = 0; j < NODES; j++) dh[j] = fmul(fmul(dout, ow[j]), slope(hid[j]));
            ob = clip(ob + fmul(dout, rate));
            for (int k = 0; k < NODES; k++) ow[k] = clip(ow[k] + fmul(fmul(hid[k], dout), rate));
            for (int j = 0; j < NODES; j++) begin
                hb[j] = clip(hb[j] + fmul(dh[j], rate));
                for (int k = 0; k < 2; k++) begin
                    hw[k*NODES + j] = clip(hw[k*NODES + j] + fmul(fmul(x[k], dh[j]), rate));
                end
            end
        end
        return 17'(o);
    endfunction

    task automatic send(t_req_item r);
        logic [16:0] p;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.kind;
        req_ch.feature_a    <= r.feat_a;
        req_ch.feature_b    <= r.feat_b;
        req_ch.target       <= r.goal;
        req_ch.weight_index <= r.widx;
        req_ch.weight_value <= r.wval;
        forever begin
            @(posedge i_clk);
            if (req_ch.ready) break;
        end
        p = network_step(r);
        pending_out.push_back(r.known ? r.known_out : p);
        case (r.kind)
            mlpbp_pkg::REQ_WRITE: n_write++;
            mlpbp_pkg::REQ_TRAIN: n_train++;
            mlpbp_pkg::REQ_PREDICT: n_pred++;
            default: n_other++;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_out.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_rate(logic [mlpbp_pkg::LR_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        rate = v;
    endtask

    function automatic t_req_item mk(mlpbp_pkg::t_req k, logic [23:0] a, logic [23:0] b,
                                     logic [23:0] g, logic [4:0] i, logic [23:0] v,
                                     bit kn, logic [16:0] ko);
        t_req_item r;
        r.kind = k; r.feat_a = a; r.feat_b = b; r.goal = g;
        r.widx = i; r.wval = v; r.known = kn; r.known_out = ko;
        return r;
    endfunction

    function automatic logic [23:0] rand_val(int mag);
        logic [23:0] v;
        if ($urandom_range(0, 7) == 0) begin
            v = 24'($urandom);
        end else begin
            v = 24'($signed($urandom_range(0, 2*mag)) - mag);
        end
        return v;
    endfunction

    function automatic t_req_item rand_req();
        t_req_item r;
        int sel;
        sel = $urandom_range(0, 99);
        r = mk(mlpbp_pkg::REQ_PREDICT, rand_val(131072), rand_val(131072),
               24'($urandom_range(0, 65536)), 5'($urandom_range(0, 16)),
               rand_val(196608), 1'b0, '0);
        if ($urandom_range(0, 9) == 0) r.goal = 24'($urandom);
        if (sel < 30) begin
            r.kind = mlpbp_pkg::REQ_WRITE;
            if ($urandom_range(0, 9) == 0) r.widx = 5'($urandom);
        end else if (sel < 75) begin
            r.kind = mlpbp_pkg::REQ_TRAIN;
        end else if (sel < 97) begin
            r.kind = mlpbp_pkg::REQ_PREDICT;
        end else begin
            r.kind = mlpbp_pkg::REQ_NONE;
            r.widx = 5'($urandom);
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (quiet) begin
            rsp_ch.ready <= 1'b1;
        end else if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= $urandom_range(0, 18);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_rsp++;
            if (pending_out.size() == 0) begin
                $error("unexpected response transaction, prediction %0d", rsp_ch.prediction);
                errors++;
            end else begin
                logic [16:0] want;
                want = pending_out.pop_front();
                if (rsp_ch.prediction !== want) begin
                    $error("prediction: expected %0d, actual %0d", want, rsp_ch.prediction);
                    errors++;
                end
            end
        end
    end

    initial begin
        #25ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_req_item plan [$];
        logic [mlpbp_pkg::LR_W-1:0] rates [5];
        req_ch.valid        = 1'b0;
        req_ch.req_type     = mlpbp_pkg::REQ_NONE;
        req_ch.feature_a    = '0;
        req_ch.feature_b    = '0;
        req_ch.target       = '0;
        req_ch.weight_index = '0;
        req_ch.weight_value = '0;
        fill_sigmoid();
        clear_network();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        plan = '{
            mk(mlpbp_pkg::REQ_PREDICT, 24'h000000, 24'h000000, 24'h000000, 5'd0, 24'h0,
               1, 17'd32768),
            mk(mlpbp_pkg::REQ_PREDICT, 24'h7FFFFF, 24'h800000, 24'h000000, 5'd0, 24'h0,
               1, 17'd32768),
            mk(mlpbp_pkg::REQ_TRAIN,   24'h7FFFFF, 24'h800000, 24'h000000, 5'd0, 24'h0,
               1, 17'd32768),
            mk(mlpbp_pkg::REQ_NONE,    24'h123456, 24'h654321, 24'h7FFFFF, 5'd31, 24'hFFFFFF,
               1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd0,  24'h7FFFFF, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd16, 24'h800000, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd17, 24'h7FFFFF, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd31, 24'h7FFFFF, 1, 17'd0),
            mk(mlpbp_pkg::REQ_PREDICT, 24'h010000, 24'hFF0000, 24'h0, 5'd0, 24'h0, 0, '0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd8,  24'hFF0000, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd12, 24'h020000, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd15, 24'hFE0000, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd11, 24'h018000, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd7,  24'hFFC000, 1, 17'd0),
            mk(mlpbp_pkg::REQ_WRITE,   24'h0, 24'h0, 24'h0, 5'd16, 24'h004000, 1, 17'd0),
            mk(mlpbp_pkg::REQ_PREDICT, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 5'd0, 24'h0, 0, '0),
            mk(mlpbp_pkg::REQ_PREDICT, 24'h800000, 24'h800000, 24'h0, 5'd0, 24'h0, 0, '0),
            mk(mlpbp_pkg::REQ_TRAIN,   24'h010000, 24'h000000, 24'h7FFFFF, 5'd0, 24'h0, 0, '0),
            mk(mlpbp_pkg::REQ_TRAIN,   24'hFF0000, 24'h008000, 24'h800000, 5'd0, 24'h0, 0, '0),
            mk(mlpbp_pkg::REQ_TRAIN,   24'h000000, 24'h010000, 24'h010000, 5'd0, 24'h0, 0, '0),
            mk(mlpbp_pkg::REQ_PREDICT, 24'h008000, 24'hFF8000, 24'h0, 5'd0, 24'h0, 0, '0)
        };
        foreach (plan[i]) send(plan[i]);

        rates = '{23'd0, 23'h7FFFFF, 23'd6554, 23'($urandom), mlpbp_pkg::LR_RESET};
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            set_rate(rates[ph]);
            for (int n = 0; n < RAND_REQS / 5; n++) begin
                if (ph == 2 && n == 100) drain();
                if (ph == 4 && n >= RAND_REQS / 5 - QUIET_TAIL) quiet = 1'b1;
                send(rand_req());
            end
        end
        drain();
        repeat (200) @(negedge i_clk);

        if (pending_out.size() != 0) begin
            $error("%0d expected responses never arrived", pending_out.size());
            errors++;
        end
        $display("Covered %0d train, %0d predict, %0d write and %0d unused-code requests,",
                 n_train, n_pred, n_write, n_other);
        $display("%0d responses checked over five learning rate settings.", n_rsp);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
